// ----- rtl/ray_sphere_intersect_top_defines.svh -----
// Assertion macros shared by the ray/sphere intersection RTL.
`ifndef RAY_SPHERE_INTERSECT_TOP_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RSI_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, clocked on clk, checked during reset too.
`define RSI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/rsi_pkg.sv -----
// Types and constants for the ray/sphere intersection pipeline.
package rsi_pkg;

  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 15;
  localparam int CFG_AW   = 2;
  localparam int DIST_W   = 32;
  localparam int A_W      = 32;   // a = D.D
  localparam int H_W      = 34;   // h = V.D, signed
  localparam int C_W      = 35;   // c = V.V - r*r, signed
  localparam int DISC_W   = 68;   // quarter discriminant
  localparam int SQRT_BITS = 34;  // root bits, one per stage
  localparam int NUM_W    = 36;   // -h - s, signed
  localparam int QUO_BITS = 31;   // quotient bits below saturation, one per stage
  localparam int DIVD_W   = 51;   // |num| << 16

  localparam logic [CFG_AW-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_AW-1:0] REG_RADIUS   = 2'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd256;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0]   DIST_MIN     = 32'h8000_0000;

  // Per-ray control and operands carried alongside the square root.
  typedef struct packed {
    logic                  zero;
    logic                  miss;
    logic [A_W-1:0]        a;
    logic signed [H_W-1:0] h;
  } ray_ctl_t;

  // Divider stage payload.
  typedef struct packed {
    logic                zero;
    logic                miss;
    logic                neg;
    logic                sat;
    logic [A_W-1:0]      a;
    logic [A_W-1:0]      rem;
    logic [QUO_BITS-1:0] low;
    logic [QUO_BITS-1:0] quo;
  } div_stage_t;

endpackage

// ----- rtl/ray_sphere_intersect_top.sv -----
// Ray against sphere intersection pipeline, top level.
//
// Usage:
//   in_*  : one ray request per accepted beat. in_tdata holds, from bit 0 up,
//           origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (16b signed each).
//   out_* : one result per ray, in order. out_tdata = distance (Q16.16, signed,
//           saturated, 0 on miss or zero direction); out_tuser = {zero_direction, hit}.
//   cfg_* : register writes, index 0..2 = center x/y/z, 3 = radius (low 15 bits).
//           Always ready; write only while no ray is in flight.
// Throughput is one ray per cycle while the receiver keeps up: each stage is a
// register slice, the square root resolves one root bit per stage (34 stages)
// and the divider one quotient bit per stage (31).
// Reset empties the pipeline and loads center 0, radius 1.0.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
module ray_sphere_intersect_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [6*rsi_pkg::COORD_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // distance
  output logic [rsi_pkg::DIST_W-1:0]         out_tdata,
  // hit, zero_direction
  output logic [1:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsi_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [rsi_pkg::COORD_W-1:0]        cfg_data
);
  import rsi_pkg::*;
  `include "ray_sphere_intersect_top_defines.svh"

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // ---------------- configuration ----------------
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [RADIUS_W-1:0]       rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= RADIUS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_CENTER_X: cx_r  <= cfg_data;
        REG_CENTER_Y: cy_r  <= cfg_data;
        REG_CENTER_Z: cz_r  <= cfg_data;
        REG_RADIUS:   rad_r <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: V = O - C ----------------
  logic signed [COORD_W-1:0] ox, oy, oz;
  assign ox = in_tdata[0*COORD_W +: COORD_W];
  assign oy = in_tdata[1*COORD_W +: COORD_W];
  assign oz = in_tdata[2*COORD_W +: COORD_W];

  logic                      v1_r;
  logic signed [COORD_W:0]   vx1_r, vy1_r, vz1_r;
  logic signed [COORD_W-1:0] dx1_r, dy1_r, dz1_r;
  logic                      zero1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx1_r   <= {ox[COORD_W-1], ox} - {cx_r[COORD_W-1], cx_r};
      vy1_r   <= {oy[COORD_W-1], oy} - {cy_r[COORD_W-1], cy_r};
      vz1_r   <= {oz[COORD_W-1], oz} - {cz_r[COORD_W-1], cz_r};
      dx1_r   <= in_tdata[3*COORD_W +: COORD_W];
      dy1_r   <= in_tdata[4*COORD_W +: COORD_W];
      dz1_r   <= in_tdata[5*COORD_W +: COORD_W];
      zero1_r <= (in_tdata[3*COORD_W +: 3*COORD_W] == '0);
    end
  end

  // ---------------- stage 2: products ----------------
  logic               v2_r, zero2_r;
  logic signed [31:0] ddx2_r, ddy2_r, ddz2_r;
  logic signed [32:0] vdx2_r, vdy2_r, vdz2_r;
  logic signed [33:0] vvx2_r, vvy2_r, vvz2_r;
  logic [29:0]        rr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero2_r <= zero1_r;
      ddx2_r  <= dx1_r * dx1_r;
      ddy2_r  <= dy1_r * dy1_r;
      ddz2_r  <= dz1_r * dz1_r;
      vdx2_r  <= vx1_r * dx1_r;
      vdy2_r  <= vy1_r * dy1_r;
      vdz2_r  <= vz1_r * dz1_r;
      vvx2_r  <= vx1_r * vx1_r;
      vvy2_r  <= vy1_r * vy1_r;
      vvz2_r  <= vz1_r * vz1_r;
      rr2_r   <= rad_r * rad_r;
    end
  end

  // ---------------- stage 3: a, h, c ----------------
  logic                  v3_r, zero3_r;
  logic [A_W-1:0]        a3_r;
  logic signed [H_W-1:0] h3_r;
  logic signed [C_W-1:0] c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero3_r <= zero2_r;
      a3_r    <= A_W'(ddx2_r) + A_W'(ddy2_r) + A_W'(ddz2_r);
      h3_r    <= H_W'(vdx2_r) + H_W'(vdy2_r) + H_W'(vdz2_r);
      c3_r    <= C_W'(vvx2_r) + C_W'(vvy2_r) + C_W'(vvz2_r) - C_W'(rr2_r);
    end
  end

  // ---------------- stage 4: partial products of h*h and a*|c| ----------------
  logic [H_W-2:0] mh3;   // |h|, 33 bits
  logic [C_W-2:0] mc3;   // |c|, 34 bits
  assign mh3 = h3_r[H_W-1] ? (H_W-1)'(-h3_r) : h3_r[H_W-2:0];
  assign mc3 = c3_r[C_W-1] ? (C_W-1)'(-c3_r) : c3_r[C_W-2:0];

  logic           v4_r, zero4_r, cneg4_r;
  logic [A_W-1:0] a4_r;
  logic signed [H_W-1:0] h4_r;
  logic [31:0]    hll4_r;
  logic [32:0]    hlh4_r;
  logic [33:0]    hhh4_r;
  logic [48:0]    acl4_r, ach4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero4_r <= zero3_r;
      cneg4_r <= c3_r[C_W-1];
      a4_r    <= a3_r;
      h4_r    <= h3_r;
      hll4_r  <= mh3[15:0] * mh3[15:0];
      hlh4_r  <= mh3[15:0] * mh3[32:16];
      hhh4_r  <= mh3[32:16] * mh3[32:16];
      acl4_r  <= a3_r * mc3[16:0];
      ach4_r  <= a3_r * mc3[33:17];
    end
  end

  // ---------------- stage 5: h*h and a*|c| ----------------
  logic              v5_r, zero5_r, cneg5_r;
  logic [A_W-1:0]    a5_r;
  logic signed [H_W-1:0] h5_r;
  logic [DISC_W-1:0] hh5_r, ac5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero5_r <= zero4_r;
      cneg5_r <= cneg4_r;
      a5_r    <= a4_r;
      h5_r    <= h4_r;
      hh5_r   <= (DISC_W'(hhh4_r) << 32) + (DISC_W'(hlh4_r) << 17) + DISC_W'(hll4_r);
      ac5_r   <= (DISC_W'(ach4_r) << 17) + DISC_W'(acl4_r);
    end
  end

  // ---------------- stage 6: discriminant, then square root ----------------
  logic                  sq_vld_r  [0:SQRT_BITS];
  logic [DISC_W-1:0]     sq_rem_r  [0:SQRT_BITS];
  logic [SQRT_BITS-1:0]  sq_root_r [0:SQRT_BITS];
  ray_ctl_t              sq_ctl_r  [0:SQRT_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else if (en) sq_vld_r[0] <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= cneg5_r ? hh5_r + ac5_r : hh5_r - ac5_r;
      sq_root_r[0] <= '0;
      sq_ctl_r[0]  <= '{zero: zero5_r, miss: !cneg5_r && (hh5_r < ac5_r),
                        a: a5_r, h: h5_r};
    end
  end

  // One root bit per stage, most significant first; remainder = v - root^2.
  for (genvar k = 1; k <= SQRT_BITS; k++) begin : g_sqrt
    localparam int B = SQRT_BITS - k;
    logic [DISC_W-1:0] trial;
    logic              take;
    assign trial = (DISC_W'(sq_root_r[k-1]) << (B + 1)) | (DISC_W'(1) << (2 * B));
    assign take  = sq_rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k] <= 1'b0;
      else if (en) sq_vld_r[k] <= sq_vld_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]  <= take ? sq_rem_r[k-1] - trial : sq_rem_r[k-1];
        sq_root_r[k] <= sq_root_r[k-1] | (take ? (SQRT_BITS'(1) << B) : '0);
        sq_ctl_r[k]  <= sq_ctl_r[k-1];
      end
    end
  end

  // ---------------- numerator -h - s ----------------
  ray_ctl_t              ctl_q;
  logic signed [NUM_W-1:0] num;
  assign ctl_q = sq_ctl_r[SQRT_BITS];
  assign num   = -NUM_W'(ctl_q.h) - NUM_W'(sq_root_r[SQRT_BITS]);

  logic              nm_vld_r, nm_neg_r;
  logic [NUM_W-2:0]  nm_mag_r;
  ray_ctl_t          nm_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) nm_vld_r <= 1'b0;
    else if (en) nm_vld_r <= sq_vld_r[SQRT_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_neg_r <= num[NUM_W-1];
      nm_mag_r <= num[NUM_W-1] ? (NUM_W-1)'(-num) : num[NUM_W-2:0];
      nm_ctl_r <= ctl_q;
    end
  end

  // ---------------- divider: saturation test, then one bit per stage ----------------
  logic [DIVD_W-1:0] divd;
  assign divd = {nm_mag_r, 16'h0};

  logic       dv_vld_r [0:QUO_BITS];
  div_stage_t dv_r     [0:QUO_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (en) dv_vld_r[0] <= nm_vld_r;
  end

  // Quotient reaches 2^31 exactly when dividend >> 31 is at least a.
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= '{zero: nm_ctl_r.zero, miss: nm_ctl_r.miss, neg: nm_neg_r,
                   sat: A_W'(divd[DIVD_W-1:QUO_BITS]) >= nm_ctl_r.a,
                   a: nm_ctl_r.a, rem: A_W'(divd[DIVD_W-1:QUO_BITS]),
                   low: divd[QUO_BITS-1:0], quo: '0};
    end
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
    localparam int B = QUO_BITS - k;
    logic [A_W:0] rem2;
    logic         take;
    div_stage_t   stage_nxt;
    assign rem2 = {dv_r[k-1].rem, dv_r[k-1].low[B]};
    assign take = rem2 >= {1'b0, dv_r[k-1].a};

    always_comb begin
      stage_nxt     = dv_r[k-1];
      stage_nxt.rem = take ? A_W'(rem2 - {1'b0, dv_r[k-1].a}) : rem2[A_W-1:0];
      stage_nxt.quo = dv_r[k-1].quo | (take ? (QUO_BITS'(1) << B) : '0);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k] <= 1'b0;
      else if (en) dv_vld_r[k] <= dv_vld_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= stage_nxt;
      end
    end
  end

  // ---------------- output register ----------------
  div_stage_t         fin;
  logic [DIST_W-1:0]  dist_nxt;
  logic               hit_nxt;
  assign fin     = dv_r[QUO_BITS];
  assign hit_nxt = !fin.zero && !fin.miss;

  always_comb begin
    priority if (!hit_nxt) dist_nxt = '0;
    else if (fin.sat)      dist_nxt = fin.neg ? DIST_MIN : DIST_MAX;
    else if (fin.neg)      dist_nxt = -{1'b0, fin.quo};
    else                   dist_nxt = {1'b0, fin.quo};
  end

  logic              out_vld_r, hit_r, zero_r;
  logic [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv_vld_r[QUO_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      zero_r <= fin.zero;
      dist_r <= dist_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = dist_r;
  assign out_tuser  = {zero_r, hit_r};

  // ---------------- checks ----------------
  `RSI_ASSERT_IMPL(a_flags_excl, out_tvalid, !(hit_r && zero_r), "hit with zero direction")
  `RSI_ASSERT_IMPL(a_miss_zero, out_tvalid && !hit_r, dist_r == '0, "miss with nonzero distance")
  `RSI_ASSERT_IMPL(a_sqrt_floor, sq_vld_r[SQRT_BITS],
    sq_rem_r[SQRT_BITS] <= (DISC_W'(sq_root_r[SQRT_BITS]) << 1), "root not floor")
  `RSI_ASSERT_NEXT(a_reset_empty, !rst_n, !out_tvalid && !sq_vld_r[0], "pipeline not empty after reset")

endmodule

// ----- test/ray_sphere_intersect_checker.sv -----
// Scoreboard for the ray/sphere intersection pipeline: predicts and checks every result.
`timescale 1ns / 100ps

module ray_sphere_intersect_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [6*rsi_pkg::COORD_W-1:0]    in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [rsi_pkg::DIST_W-1:0]       out_tdata,
  input  logic [1:0]                       out_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rsi_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [rsi_pkg::COORD_W-1:0]      cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import rsi_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              zero_dir;
    logic [DIST_W-1:0] distance;
  } hit_result_t;

  logic signed [COORD_W-1:0] sph_cx, sph_cy, sph_cz;
  logic [RADIUS_W-1:0]       sph_r;
  hit_result_t               expected_hits[$];

  function automatic hit_result_t intersect_ray(logic [6*COORD_W-1:0] ray);
    hit_result_t        res;
    longint             vx, vy, vz, dx, dy, dz, a, h, c, num, q;
    logic signed [127:0] hw, aw, cw, disc;
    logic [127:0]       root, cand;
    vx = longint'($signed(ray[0*COORD_W +: COORD_W])) - longint'(sph_cx);
    vy = longint'($signed(ray[1*COORD_W +: COORD_W])) - longint'(sph_cy);
    vz = longint'($signed(ray[2*COORD_W +: COORD_W])) - longint'(sph_cz);
    dx = longint'($signed(ray[3*COORD_W +: COORD_W]));
    dy = longint'($signed(ray[4*COORD_W +: COORD_W]));
    dz = longint'($signed(ray[5*COORD_W +: COORD_W]));
    a = dx*dx + dy*dy + dz*dz;
    h = vx*dx + vy*dy + vz*dz;
    c = vx*vx + vy*vy + vz*vz - longint'(sph_r) * longint'(sph_r);
    res = '0;
    if (a == 0) begin
      res.zero_dir = 1'b1;
      return res;
    end
    hw = h;
    aw = a;
    cw = c;
    disc = hw*hw - aw*cw;
    if (disc < 0) return res;     // miss
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand*cand <= $unsigned(disc)) root = cand;
    end
    num = -h - longint'(root);
    q = (num * 65536) / a;        // truncates toward zero
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    res.hit = 1'b1;
    res.distance = q[DIST_W-1:0];
    return res;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    hit_result_t exp_r;
    if (!rst_n) begin
      sph_cx <= '0;
      sph_cy <= '0;
      sph_cz <= '0;
      sph_r  <= RADIUS_RESET;
      expected_hits.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_CENTER_X: sph_cx <= cfg_data;
          REG_CENTER_Y: sph_cy <= cfg_data;
          REG_CENTER_Z: sph_cz <= cfg_data;
          REG_RADIUS:   sph_r  <= cfg_data[RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_hits.push_back(intersect_ray(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, actual hit=%0b zero=%0b dist=%0d", $time,
                   out_tuser[0], out_tuser[1], $signed(out_tdata));
        end else begin
          exp_r = expected_hits.pop_front();
          if (exp_r.hit !== out_tuser[0]) begin
            fail_count++;
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, exp_r.hit,
                     out_tuser[0]);
          end
          if (exp_r.zero_dir !== out_tuser[1]) begin
            fail_count++;
            $display("%0t: zero_direction mismatch, expected %0b actual %0b", $time,
                     exp_r.zero_dir, out_tuser[1]);
          end
          if (exp_r.distance !== out_tdata) begin
            fail_count++;
            $display("%0t: distance mismatch, expected %0d actual %0d", $time,
                     $signed(exp_r.distance), $signed(out_tdata));
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_ray_sphere_intersect_top.sv -----
// Stimulus and verdict for the ray/sphere intersection pipeline.
`timescale 1ns / 100ps

module tb_ray_sphere_intersect_top;
  import rsi_pkg::*;

  localparam int LATENCY    = 74;
  localparam int CYCLE_MAX  = 400000;
  localparam int RAYS_PHASE = 150;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [6*COORD_W-1:0] in_tdata;      // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DIST_W-1:0]    out_tdata;     // distance
  logic [1:0]           out_tuser;     // hit, zero_direction
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_AW-1:0]    cfg_addr;
  logic [COORD_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int cycles;
  int send_idle_pct;     // chance in 100 that the sender leaves a gap
  int recv_stall_pct;    // chance in 100 that the receiver drops tready

  // sphere as currently programmed, used to aim rays
  int cur_cx, cur_cy, cur_cz, cur_r;

  ray_sphere_intersect_top u_top (.*);

  ray_sphere_intersect_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [COORD_W-1:0] clamp16(int v);
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_W-1:0];
  endfunction

  // one ray request; optional gap first, valid stays high between back-to-back requests
  task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {clamp16(dz), clamp16(dy), clamp16(dx), clamp16(oz), clamp16(oy), clamp16(ox)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // program the sphere; only ever called with the pipeline empty
  task automatic set_sphere(int cx, int cy, int cz, int r);
    int vals[4];
    drain();
    repeat (LATENCY + 6) @(posedge clk);
    vals = '{cx, cy, cz, r};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_addr <= i[CFG_AW-1:0];
      cfg_data <= vals[i][COORD_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_cx = cx; cur_cy = cy; cur_cz = cz; cur_r = r;
  endtask

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  // random ray: mostly aimed near the sphere, some inside it, some pure noise
  task automatic random_ray;
    int kind, ox, oy, oz, sp, jit;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_ray(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
    end else if (kind < 20) begin
      // tiny components, zero direction now and then
      send_ray(rnd16(), rnd16(), rnd16(), $urandom_range(2) - 1, $urandom_range(2) - 1,
               $urandom_range(2) - 1);
    end else begin
      sp  = (kind < 35) ? cur_r : 4 * cur_r + 2000;
      ox  = cur_cx + $urandom_range(2*sp) - sp;
      oy  = cur_cy + $urandom_range(2*sp) - sp;
      oz  = cur_cz + $urandom_range(2*sp) - sp;
      jit = cur_r / 2 + 1;
      send_ray(ox, oy, oz,
               cur_cx - ox + $urandom_range(2*jit) - jit,
               cur_cy - oy + $urandom_range(2*jit) - jit,
               cur_cz - oz + $urandom_range(2*jit) - jit);
    end
  endtask

  initial begin
    int sph[7][4];
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_addr       = '0;
    cfg_data       = '0;
    send_idle_pct  = 25;
    recv_stall_pct = 74;
    cur_cx = 0; cur_cy = 0; cur_cz = 0; cur_r = 256;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset sphere: center 0, radius 1.0
    send_ray(-512, 0, 0, 256, 0, 0);             // plain hit, t = 1.0
    send_ray(-512, 256, 0, 256, 0, 0);           // tangent
    send_ray(-512, 300, 0, 256, 0, 0);           // just misses
    send_ray(0, 0, 0, 0, 256, 0);                // inside, nearer root behind origin
    send_ray(512, 0, 0, 256, 0, 0);              // sphere fully behind
    send_ray(100, -200, 300, 0, 0, 0);           // zero direction
    send_ray(-32768, 0, 0, 1, 0, 0);             // huge t, just short of saturation
    send_ray(32767, 0, 0, 1, 0, 0);              // huge negative t, saturates low
    send_ray(-32768, -32768, -32768, 32767, 32767, 32767);
    send_ray(32767, 32767, 32767, -32768, -32768, -32768);
    send_ray(-32768, -32768, -32768, -32768, -32768, -32768);
    send_ray(32767, 32767, 32767, 32767, 32767, 32767);
    send_ray(0, 0, -1024, 0, 0, -32768);
    send_ray(-1, -1, -1, 1, 1, 1);
    // extreme sphere: corner center, largest radius
    set_sphere(-32768, 32767, -32768, 32767);
    send_ray(32767, -32768, 32767, -32768, 32767, -32768);
    send_ray(-32768, 32767, -32768, 0, 0, 1);    // origin at center
    send_ray(32767, 32767, 32767, 0, 0, 0);
    // degenerate sphere, radius 0
    set_sphere(0, 0, 0, 0);
    send_ray(-256, 0, 0, 1, 0, 0);               // passes through the point
    send_ray(-256, 1, 0, 1, 0, 0);
    send_ray(0, 0, 0, 5, -7, 3);

    sph[0] = '{0, 0, 0, 256};
    sph[1] = '{32767, -32768, 32767, 32767};
    sph[2] = '{1000, -2000, 3000, 1500};
    sph[3] = '{-32768, -32768, -32768, 0};
    sph[4] = '{-5000, 7000, 200, 64};
    sph[5] = '{12345, 0, -12345, 20000};
    sph[6] = '{-1, 1, -1, 32767};

    for (int p = 0; p < 7; p++) begin
      // idling: sender-light first, then receiver-light, then none
      if (p < 2)      begin send_idle_pct = 25; recv_stall_pct = 74; end
      else if (p < 4) begin send_idle_pct = 74; recv_stall_pct = 25; end
      else            begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      set_sphere(sph[p][0], sph[p][1], sph[p][2], sph[p][3]);
      for (int i = 0; i < RAYS_PHASE; i++) begin
        random_ray();
        // hold off until the pipeline has emptied, once mid-run
        if (p == 4 && i == RAYS_PHASE / 2) drain();
      end
    end

    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
